### rtl/egsd_pkg.sv
// ----------------------------------------------------------------------------
// egsd_pkg
// Shared types and constants of the Exp-Golomb stream decoder.
// ----------------------------------------------------------------------------
package egsd_pkg;

	localparam int BYTE_W      = 8;
	localparam int N_SLOT      = BYTE_W;
	localparam int ZC_W        = 5;
	localparam int SUF_W       = 31;
	localparam int VALUE_W     = 33;
	localparam int OUT_TDATA_W = 40;
	localparam int MAX_PREFIX  = 31;

	localparam logic PH_PREFIX = 1'b0;
	localparam logic PH_SUFFIX = 1'b1;

	typedef struct packed {
		logic              phase;
		logic [ZC_W-1:0]   zero_count;
		logic [ZC_W-1:0]   suffix_left;
		logic [SUF_W-1:0]  suffix_accum;
	} dec_state_t;

	// One completed code: prefix length and suffix bits, or an overflow mark.
	typedef struct packed {
		logic              ovf;
		logic [ZC_W-1:0]   zeros;
		logic [SUF_W-1:0]  suffix;
	} slot_t;

	localparam dec_state_t STATE_CLEAR = '0;

endpackage

### rtl/egsd_walk.sv
// ----------------------------------------------------------------------------
// egsd_walk
// Steps the code parser through the eight bits of one byte, MSB first, and
// reports every code that completes, one slot per bit position.
// ----------------------------------------------------------------------------
module egsd_walk (
	input  logic [egsd_pkg::BYTE_W-1:0]              data_byte,
	input  logic                                     restart,
	input  egsd_pkg::dec_state_t                     st_in,
	output egsd_pkg::dec_state_t                     st_out,
	output logic [egsd_pkg::N_SLOT-1:0]              done,
	output egsd_pkg::slot_t [egsd_pkg::N_SLOT-1:0]   slots
);
	import egsd_pkg::*;

	always_comb begin
		dec_state_t st;
		logic       bit_v;
		st = restart ? STATE_CLEAR : st_in;
		done  = '0;
		slots = '0;
		for (int k = 0; k < N_SLOT; k++) begin
			bit_v = data_byte[BYTE_W-1-k];
			if (st.phase == PH_PREFIX) begin
				if (!bit_v) begin
					if (st.zero_count >= ZC_W'(MAX_PREFIX)) begin
						done[k]      = 1'b1;
						slots[k].ovf = 1'b1;
						st           = STATE_CLEAR;
					end else begin
						st.zero_count = st.zero_count + ZC_W'(1);
					end
				end else if (st.zero_count == '0) begin
					// A lone one bit is code zero.
					done[k] = 1'b1;
					st      = STATE_CLEAR;
				end else begin
					st.phase        = PH_SUFFIX;
					st.suffix_left  = st.zero_count;
					st.suffix_accum = '0;
				end
			end else begin
				st.suffix_accum = {st.suffix_accum[SUF_W-2:0], bit_v};
				st.suffix_left  = st.suffix_left - ZC_W'(1);
				if (st.suffix_left == '0) begin
					done[k]         = 1'b1;
					slots[k].zeros  = st.zero_count;
					slots[k].suffix = st.suffix_accum;
					st              = STATE_CLEAR;
				end
			end
		end
		st_out = st;
	end

endmodule

### rtl/egsd_emit.sv
// ----------------------------------------------------------------------------
// egsd_emit
// Holds the codes completed by one byte and sends them out one word per
// cycle unless the output stalls, mapping each to its unsigned or signed value.
// ----------------------------------------------------------------------------
module egsd_emit (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     load,
	input  logic [egsd_pkg::N_SLOT-1:0]              load_done,
	input  egsd_pkg::slot_t [egsd_pkg::N_SLOT-1:0]   load_slots,
	input  logic                                     signed_mode,
	output logic                                     can_load,
	output logic                                     m_axis_tvalid,
	input  logic                                     m_axis_tready,
	output logic [egsd_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,  // value[32:0], zero pad
	output logic                                     m_axis_tuser,  // prefix_overflow
	output logic                                     m_axis_tlast
);
	import egsd_pkg::*;

	logic [N_SLOT-1:0]        pend_q;
	slot_t [N_SLOT-1:0]       slots_s2;
	logic [N_SLOT-1:0]        pick_oh;
	logic [N_SLOT-1:0]        rest;
	slot_t                    sel;
	logic                     out_ready;
	logic                     fire;
	logic [VALUE_W-1:0]       t_val;
	logic [VALUE_W-1:0]       mag;
	logic [VALUE_W-1:0]       value;
	logic                     tvalid_q;
	logic [OUT_TDATA_W-1:0]   tdata_q;
	logic                     tuser_q;
	logic                     tlast_q;

	// Slot zero holds the code finished by the first bit, so the lowest set
	// pending bit is the next word in stream order.
	assign pick_oh   = pend_q & (~pend_q + N_SLOT'(1));
	assign rest      = pend_q & ~pick_oh;
	assign out_ready = !tvalid_q || m_axis_tready;
	assign fire      = (pend_q != '0) && out_ready;
	assign can_load  = (pend_q == '0) || (fire && (rest == '0));

	always_comb begin
		sel = '0;
		for (int k = 0; k < N_SLOT; k++) begin
			if (pick_oh[k]) begin
				sel = slots_s2[k];
			end
		end
	end

	// 2^zeros - 1 + suffix: the suffix is below 2^zeros, so the sum is an OR
	// followed by a decrement. The signed magnitude is that OR shifted down.
	always_comb begin
		t_val = (VALUE_W'(1) << sel.zeros) | VALUE_W'(sel.suffix);
		mag   = t_val >> 1;
		if (sel.ovf) begin
			value = '0;
		end else if (!signed_mode) begin
			value = t_val - VALUE_W'(1);
		end else if (t_val[0]) begin
			value = '0 - mag;
		end else begin
			value = mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= '0;
			tvalid_q <= 1'b0;
		end else begin
			if (load) begin
				pend_q <= load_done;
			end else if (fire) begin
				pend_q <= rest;
			end
			if (fire) begin
				tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slots_s2 <= load_slots;
		end
		if (fire) begin
			tdata_q <= OUT_TDATA_W'(value);
			tuser_q <= sel.ovf;
			tlast_q <= (rest == '0);
		end
	end

	assign m_axis_tvalid = tvalid_q;
	assign m_axis_tdata  = tdata_q;
	assign m_axis_tuser  = tuser_q;
	assign m_axis_tlast  = tlast_q;

endmodule

### rtl/exp_golomb_stream_decoder.sv
// ----------------------------------------------------------------------------
// exp_golomb_stream_decoder
// Order-0 Exp-Golomb ue(v)/se(v) decoder for a byte stream.
// ----------------------------------------------------------------------------
// Bytes enter on the slave side, MSB first; codes may span byte boundaries.
// Every completed code leaves as one word on the master side, with tlast on
// the final word caused by a byte and tuser set when a zero prefix grew past
// the limit (the value is then zero and parsing restarts). A byte is
// registered on entry, parsed into a result buffer and moved word by word
// into the output register. While the output is not stalled, the parser takes
// one byte per cycle if each byte completes at most one code; a byte that
// completes several codes holds the buffer until the output register, taking
// one word per cycle, has its last word. Bytes completing no code pass without
// using the output. The user writes signed_mode through cfg_we/cfg_wdata
// only while the decoder is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module exp_golomb_stream_decoder (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic                                  cfg_wdata,      // signed_mode
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [egsd_pkg::BYTE_W-1:0]           s_axis_tdata,   // data_byte[7:0]
	input  logic                                  s_axis_tuser,   // restart
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [egsd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,   // value[32:0], zero pad
	output logic                                  m_axis_tuser,   // prefix_overflow
	output logic                                  m_axis_tlast
);
	import egsd_pkg::*;

	logic                  signed_mode_q;
	logic                  valid_s1;
	logic [BYTE_W-1:0]     byte_s1;
	logic                  restart_s1;
	dec_state_t            state_q;
	dec_state_t            state_next;
	logic [N_SLOT-1:0]     done;
	slot_t [N_SLOT-1:0]    slots;
	logic                  can_load;
	logic                  consume;
	logic                  load;

	egsd_walk u_walk (
		.data_byte (byte_s1),
		.restart   (restart_s1),
		.st_in     (state_q),
		.st_out    (state_next),
		.done      (done),
		.slots     (slots)
	);

	// A byte with no completed code never needs the result buffer.
	assign consume       = valid_s1 && ((done == '0) || can_load);
	assign load          = consume && (done != '0);
	assign s_axis_tready = !valid_s1 || consume;

	egsd_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.load_done     (done),
		.load_slots    (slots),
		.signed_mode   (signed_mode_q),
		.can_load      (can_load),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode_q <= 1'b0;
			valid_s1      <= 1'b0;
			state_q       <= STATE_CLEAR;
		end else begin
			if (cfg_we) begin
				signed_mode_q <= cfg_wdata;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				valid_s1 <= 1'b1;
			end else if (consume) begin
				valid_s1 <= 1'b0;
			end
			if (consume) begin
				state_q <= state_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1    <= s_axis_tdata;
			restart_s1 <= s_axis_tuser;
		end
	end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Exp-Golomb stream decoder.
// ----------------------------------------------------------------------------
// Bytes go in on the slave stream and decoded codes come back on the master
// stream. An in-bench decoder follows every accepted byte and queues the words
// it should cause, or a row's typed ones; each is checked on leaving against
// the oldest queued one. A short table of hand-picked bytes comes first, then
// a few hundred bytes built mostly from valid code sequences, under both
// signed_mode settings and with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
	import egsd_pkg::*;

	typedef struct {
		logic [VALUE_W-1:0] value;
		logic               ovf;
		logic               last;
	} code_word_t;

	typedef struct {
		logic [7:0]         data;
		logic               rst;
		logic               mode;
		int                 n_typed;
		logic [VALUE_W-1:0] typed_val;
		logic               typed_ovf;
	} stim_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic                   cfg_wdata;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [BYTE_W-1:0]      s_axis_tdata;
	logic                   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;
	logic                   m_axis_tlast;

	// Bench copy of the decoder state.
	logic                   sgn_mode;
	logic                   dec_phase;
	logic [ZC_W-1:0]        dec_zeros;
	logic [ZC_W-1:0]        dec_left;
	logic [SUF_W-1:0]       dec_suffix;

	code_word_t             pending_codes[$];
	stim_row_t              dir_rows[$];
	logic                   bit_pool[$];
	code_word_t             want;
	int                     mismatches;
	bit                     idle_in;
	bit                     idle_out;

	exp_golomb_stream_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	function automatic logic [VALUE_W-1:0] map_code(input logic [63:0] code);
		logic [63:0] mag;
		logic [63:0] neg;
		mag = (code + 64'd1) >> 1;
		neg = 64'd0 - mag;
		if (!sgn_mode)
			return code[VALUE_W-1:0];
		if (code[0])
			return mag[VALUE_W-1:0];
		return neg[VALUE_W-1:0];
	endfunction

	function automatic void clear_code();
		dec_phase  = PH_PREFIX;
		dec_zeros  = '0;
		dec_left   = '0;
		dec_suffix = '0;
	endfunction

	// Walks the byte MSB first; queues the words it completes when keep is set.
	function automatic void parse_byte(input logic [7:0] b, input logic rs, input bit keep);
		code_word_t  got[$];
		code_word_t  w;
		logic [63:0] code;
		logic        bv;
		if (rs)
			clear_code();
		for (int i = 7; i >= 0; i--) begin
			bv = b[i];
			w.value = '0;
			w.ovf = 1'b0;
			w.last = 1'b0;
			if (dec_phase == PH_PREFIX) begin
				if (!bv) begin
					if (dec_zeros >= MAX_PREFIX) begin
						w.ovf = 1'b1;
						got.push_back(w);
						clear_code();
					end else begin
						dec_zeros = dec_zeros + 1'b1;
					end
				end else if (dec_zeros == 0) begin
					w.value = map_code(64'd0);
					got.push_back(w);
					clear_code();
				end else begin
					dec_phase  = PH_SUFFIX;
					dec_left   = dec_zeros;
					dec_suffix = '0;
				end
			end else begin
				dec_suffix = {dec_suffix[SUF_W-2:0], bv};
				dec_left   = dec_left - 1'b1;
				if (dec_left == 0) begin
					code = (64'd1 << dec_zeros) - 64'd1 + {33'd0, dec_suffix};
					w.value = map_code(code);
					got.push_back(w);
					clear_code();
				end
			end
		end
		if (got.size() != 0)
			got[got.size()-1].last = 1'b1;
		if (keep)
			foreach (got[k])
				pending_codes.push_back(got[k]);
	endfunction

	function automatic void add_row(input logic [7:0] data, input logic rst, input logic mode,
			input int n, input logic [VALUE_W-1:0] val, input logic ovf);
		stim_row_t r;
		r.data = data;
		r.rst = rst;
		r.mode = mode;
		r.n_typed = n;
		r.typed_val = val;
		r.typed_ovf = ovf;
		dir_rows.push_back(r);
	endfunction

	// Appends one code to the bit pool: mostly short prefixes, sometimes long
	// ones, and now and then a prefix past the limit.
	function automatic void grow_pool();
		int pick;
		int zeros;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			zeros = $urandom_range(0, 4);
		else if (pick < 90)
			zeros = $urandom_range(5, 15);
		else if (pick < 98)
			zeros = $urandom_range(16, MAX_PREFIX);
		else
			zeros = $urandom_range(MAX_PREFIX + 1, MAX_PREFIX + 4);
		repeat (zeros) bit_pool.push_back(1'b0);
		bit_pool.push_back(1'b1);
		if (zeros <= MAX_PREFIX)
			repeat (zeros) bit_pool.push_back(1'($urandom_range(0, 1)));
	endfunction

	function automatic logic [7:0] pick_byte();
		int          pick;
		logic [7:0]  b;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			while (bit_pool.size() < 8)
				grow_pool();
			for (int i = 7; i >= 0; i--)
				b[i] = bit_pool.pop_front();
		end else if (pick < 82) begin
			b = 8'($urandom_range(0, 255));
		end else if (pick < 91) begin
			b = 8'h00;
		end else begin
			b = 8'hFF;
		end
		return b;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_byte(input logic [7:0] b, input logic rs, input int n_typed,
			input logic [VALUE_W-1:0] val, input logic ovf);
		int         gap;
		code_word_t w;
		gap = idle_in ? $urandom_range(0, 8) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= rs;
		do @(posedge clk); while (!s_axis_tready);
		parse_byte(b, rs, n_typed == 0);
		for (int k = 0; k < n_typed; k++) begin
			w.value = val;
			w.ovf = ovf;
			w.last = (k == n_typed - 1);
			pending_codes.push_back(w);
		end
		@(negedge clk);
	endtask

	// The decoder is idle once the queue drains and bytes that cause no word have passed.
	task automatic set_mode(input logic m);
		s_axis_tvalid <= 1'b0;
		while (pending_codes.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sgn_mode  = m;
	endtask

	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			int stall;
			@(negedge clk);
			stall = idle_out ? $urandom_range(0, 8) : 0;
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_codes.size() == 0) begin
				mismatches++;
				$display("%0t: word with nothing expected, got value %h ovf %b last %b",
					$time, m_axis_tdata[VALUE_W-1:0], m_axis_tuser, m_axis_tlast);
			end else begin
				want = pending_codes.pop_front();
				if (m_axis_tdata[VALUE_W-1:0] !== want.value) begin
					mismatches++;
					$display("%0t: value expected %h, got %h", $time, want.value,
						m_axis_tdata[VALUE_W-1:0]);
				end
				if (m_axis_tuser !== want.ovf) begin
					mismatches++;
					$display("%0t: overflow flag expected %b, got %b", $time, want.ovf,
						m_axis_tuser);
				end
				if (m_axis_tlast !== want.last) begin
					mismatches++;
					$display("%0t: last flag expected %b, got %b", $time, want.last,
						m_axis_tlast);
				end
			end
		end
	end

	initial begin
		stim_row_t r;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		mismatches    = 0;
		idle_in       = 1'b1;
		idle_out      = 1'b1;
		sgn_mode      = 1'b0;
		clear_code();

		// Unsigned: a byte of eight zero-length codes, a prefix past the limit,
		// and the largest code number.
		add_row(8'hFF, 1'b0, 1'b0, 8, 33'd0, 1'b0);
		add_row(8'h00, 1'b1, 1'b0, 0, 33'd0, 1'b0);
		add_row(8'h00, 1'b0, 1'b0, 0, 33'd0, 1'b0);
		add_row(8'h00, 1'b0, 1'b0, 0, 33'd0, 1'b0);
		add_row(8'h00, 1'b0, 1'b0, 1, 33'd0, 1'b1);
		add_row(8'h00, 1'b1, 1'b0, 0, 33'd0, 1'b0);
		add_row(8'h00, 1'b0, 1'b0, 0, 33'd0, 1'b0);
		add_row(8'h00, 1'b0, 1'b0, 0, 33'd0, 1'b0);
		add_row(8'h01, 1'b0, 1'b0, 0, 33'd0, 1'b0);
		add_row(8'hFF, 1'b0, 1'b0, 0, 33'd0, 1'b0);
		add_row(8'hFF, 1'b0, 1'b0, 0, 33'd0, 1'b0);
		add_row(8'hFF, 1'b0, 1'b0, 0, 33'd0, 1'b0);
		add_row(8'hFE, 1'b0, 1'b0, 1, 33'h0_FFFF_FFFE, 1'b0);
		add_row(8'h5A, 1'b0, 1'b0, 0, 33'd0, 1'b0);
		add_row(8'h40, 1'b1, 1'b0, 0, 33'd0, 1'b0);
		// Signed: zero codes, one odd and one even code, the most negative value.
		add_row(8'hFF, 1'b1, 1'b1, 8, 33'd0, 1'b0);
		add_row(8'h4C, 1'b1, 1'b1, 0, 33'd0, 1'b0);
		add_row(8'h00, 1'b1, 1'b1, 0, 33'd0, 1'b0);
		add_row(8'h00, 1'b0, 1'b1, 0, 33'd0, 1'b0);
		add_row(8'h00, 1'b0, 1'b1, 0, 33'd0, 1'b0);
		add_row(8'h01, 1'b0, 1'b1, 0, 33'd0, 1'b0);
		add_row(8'hFF, 1'b0, 1'b1, 0, 33'd0, 1'b0);
		add_row(8'hFF, 1'b0, 1'b1, 0, 33'd0, 1'b0);
		add_row(8'hFF, 1'b0, 1'b1, 0, 33'd0, 1'b0);
		add_row(8'hFE, 1'b0, 1'b1, 1, 33'h1_8000_0001, 1'b0);
		add_row(8'hA5, 1'b0, 1'b1, 0, 33'd0, 1'b0);

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		set_mode(1'b0);

		foreach (dir_rows[i]) begin
			r = dir_rows[i];
			if (r.mode !== sgn_mode)
				set_mode(r.mode);
			send_byte(r.data, r.rst, r.n_typed, r.typed_val, r.typed_ovf);
		end

		for (int p = 0; p < 5; p++) begin
			case (p)
				0: begin
					set_mode(1'b1);
					idle_in  = 1'b1;
					idle_out = 1'b1;
				end
				1: begin
					set_mode(1'b0);
					idle_in  = 1'b0;
					idle_out = 1'b0;
				end
				default: begin
					set_mode(1'($urandom_range(0, 1)));
					idle_in  = 1'($urandom_range(0, 1));
					idle_out = 1'($urandom_range(0, 1));
				end
			endcase
			bit_pool.delete();
			repeat (89)
				send_byte(pick_byte(), 1'($urandom_range(0, 99) < 5), 0, 33'd0, 1'b0);
		end

		s_axis_tvalid <= 1'b0;
		while (pending_codes.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

### files.f
rtl/egsd_pkg.sv
rtl/egsd_walk.sv
rtl/egsd_emit.sv
rtl/exp_golomb_stream_decoder.sv
tb/sv/tb_top.sv
